/* sv/nrn_pkg.sv */
// nrn_pkg: shared types for the nasal / rww spelling normalizer.
// No dependencies; nrn_front, nrn_queue, nrn_back and the top refer to it by scoped names.
`default_nettype none

package nrn_pkg;

    localparam int RUN_BYTES = 4;   // most bytes one input request can produce
    localparam int CNT_W     = 3;   // holds 0..RUN_BYTES

    typedef logic [7:0]       t_sym;
    typedef logic [CNT_W-1:0] t_cnt;

    // One run: the bytes caused by one input request, bytes[0] goes out first.
    typedef struct packed {
        t_sym [RUN_BYTES-1:0] bytes;
        t_cnt                 count;
    } t_run;

    // Head of the run queue as the back end sees it.
    typedef struct packed {
        logic valid;
        t_run run;
    } t_head;

endpackage

`default_nettype wire

/* sv/nrn_if.sv */
// nrn_in_if / nrn_out_if: valid-ready channels of the spelling normalizer.
// Depends on nothing.
`default_nettype none

interface nrn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       text_end;

    modport source (output valid, output symbol, output text_end, input ready);
    modport sink   (input valid, input symbol, input text_end, output ready);
endinterface

interface nrn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       run_last;

    modport source (output valid, output out_symbol, output run_last, input ready);
    modport sink   (input valid, input out_symbol, input run_last, output ready);
endinterface

`default_nettype wire

/* sv/nrn_front.sv */
// nrn_front: accepts input bytes, tracks the pending prefix, builds one run per byte.
// Depends on nrn_pkg and nrn_in_if.
`default_nettype none

module nrn_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    nrn_in_if.sink            i_in,
    input  wire logic         i_q_ready,
    output nrn_pkg::t_run     o_run,
    output logic              o_push
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M    = 3'd1;
    localparam logic [2:0] ST_R    = 3'd2;
    localparam logic [2:0] ST_RW   = 3'd3;
    localparam logic [2:0] ST_RWW  = 3'd4;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_ANUS = "M";
    localparam logic [7:0] CH_R    = "r";
    localparam logic [7:0] CH_W    = "w";
    localparam logic [7:0] CH_LM   = "m";

    function automatic nrn_pkg::t_run f_put(nrn_pkg::t_run run, nrn_pkg::t_sym b);
        nrn_pkg::t_run res;
        res = run;
        if (run.count < nrn_pkg::CNT_W'(nrn_pkg::RUN_BYTES)) begin
            res.bytes[run.count[1:0]] = b;
            res.count = run.count + nrn_pkg::CNT_W'(1);
        end
        return res;
    endfunction

    function automatic nrn_pkg::t_run f_flush(nrn_pkg::t_run run, logic [2:0] st);
        nrn_pkg::t_run res;
        res = run;
        case (st)
            ST_M: begin
                res = f_put(res, CH_LM);
            end
            ST_R: begin
                res = f_put(res, CH_R);
            end
            ST_RW: begin
                res = f_put(res, CH_R);
                res = f_put(res, CH_W);
            end
            ST_RWW: begin
                res = f_put(res, CH_R);
                res = f_put(res, CH_W);
                res = f_put(res, CH_W);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Class nasal for the byte after an anusvara.
    function automatic nrn_pkg::t_sym f_nasal(nrn_pkg::t_sym c);
        nrn_pkg::t_sym res;
        if (c inside {"k", "K", "g", "G", "f"})      res = "f";
        else if (c inside {"c", "C", "j", "J", "F"}) res = "F";
        else if (c inside {"t", "T", "d", "D", "N"}) res = "N";
        else if (c inside {"w", "W", "x", "X", "n"}) res = "n";
        else if (c inside {"p", "P", "b", "B", "m"}) res = "m";
        else                                          res = CH_ANUS;
        return res;
    endfunction

    function automatic logic f_vowel(nrn_pkg::t_sym c);
        return c inside {"a", "A", "i", "I", "u", "U", "q", "L", "e", "E", "o", "O"};
    endfunction

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [2:0]    w_cur;
    logic          w_accept;
    nrn_pkg::t_sym w_c;
    nrn_pkg::t_run w_run;

    assign w_c      = i_in.symbol;
    assign i_in.ready = i_q_ready;
    assign w_accept = i_in.valid && i_q_ready;

    always_comb begin
        w_cur   = (r_state > ST_RWW) ? ST_IDLE : r_state;   // unused codes act as idle
        w_run   = '0;
        n_state = ST_IDLE;
        if (w_c inside {CH_SP, CH_NL, CH_TAB}) begin
            w_run = f_flush(w_run, w_cur);
            w_run = f_put(w_run, w_c);
        end else if (w_c == CH_NUL) begin
            w_run = f_flush(w_run, w_cur);              // terminator itself is dropped
        end else begin
            case (w_cur)
                ST_M: begin
                    w_run = f_put(w_run, f_nasal(w_c));
                    w_run = f_put(w_run, w_c);
                end
                ST_R: begin
                    if (w_c == CH_W) begin
                        n_state = ST_RW;
                    end else begin
                        w_run = f_put(w_run, CH_R);
                        w_run = f_put(w_run, w_c);
                    end
                end
                ST_RW: begin
                    if (w_c == CH_W) begin
                        n_state = ST_RWW;
                    end else begin
                        w_run = f_put(w_run, CH_R);
                        w_run = f_put(w_run, CH_W);
                        w_run = f_put(w_run, w_c);
                    end
                end
                ST_RWW: begin
                    w_run = f_put(w_run, CH_R);
                    w_run = f_put(w_run, CH_W);
                    if (!f_vowel(w_c)) begin
                        w_run = f_put(w_run, CH_W);
                    end
                    w_run = f_put(w_run, w_c);
                end
                default: begin
                    if (w_c == CH_ANUS) begin
                        n_state = ST_M;
                    end else if (w_c == CH_R) begin
                        n_state = ST_R;
                    end else begin
                        w_run = f_put(w_run, w_c);
                    end
                end
            endcase
        end
        if (i_in.text_end) begin
            w_run   = f_flush(w_run, n_state);
            n_state = ST_IDLE;
        end
    end

    assign o_run  = w_run;
    assign o_push = w_accept && (w_run.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* sv/nrn_queue.sv */
// nrn_queue: short run queue between the front and back ends.
// Depends on nrn_pkg.
`default_nettype none

module nrn_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire nrn_pkg::t_run i_run,
    output logic               o_ready,
    input  wire logic          i_pop,
    output nrn_pkg::t_head     o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    nrn_pkg::t_run    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready      = (r_cnt != CNT_FULL);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.run   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/nrn_back.sv */
// nrn_back: drains the head run one byte per cycle into the output register while it is not stalled.
// Depends on nrn_pkg and nrn_out_if.
`default_nettype none

module nrn_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire nrn_pkg::t_head i_head,
    output logic                o_pop,
    nrn_out_if.source           o_out
);

    logic [1:0]    r_pos;
    logic          r_valid;
    nrn_pkg::t_sym r_sym;
    logic          r_last;
    logic          w_load_ok;
    logic          w_emit;
    logic          w_last;

    assign w_load_ok = !r_valid || o_out.ready;
    assign w_emit    = i_head.valid && w_load_ok;
    assign w_last    = ((nrn_pkg::CNT_W'(r_pos) + nrn_pkg::CNT_W'(1)) == i_head.run.count);
    assign o_pop     = w_emit && w_last;

    assign o_out.valid      = r_valid;
    assign o_out.out_symbol = r_sym;
    assign o_out.run_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
                r_pos   <= w_last ? '0 : r_pos + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sym  <= i_head.run.bytes[r_pos];
            r_last <= w_last;
        end
    end

endmodule

`default_nettype wire

/* sv/nasal_and_rww_spelling_normaliser_core.sv */
// Top level of the nasal / rww spelling normalizer.
// Depends on nrn_pkg, nrn_if, nrn_front, nrn_queue and nrn_back.
//
//  Channel  Dir  Handshake        Payload
//  i_in     in   valid / ready    symbol[7:0], text_end
//  o_out    out  valid / ready    out_symbol[7:0], run_last
//
// One input request is taken per cycle while the run queue has room.
// A request yields 0..4 bytes; the back end drains one byte per cycle while o_out
// is not stalled. From accept to o_out a run passes the run queue, then the
// output register.
// Synchronous active-low reset clears the prefix state, queue and output
// register; there is no clearing pass.
// Input stalls only when the queue is full; output stalls back up into it.
`default_nettype none

module nasal_and_rww_spelling_normaliser_core #(
    parameter int P_QUEUE_DEPTH = 2     // runs buffered between front and back
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nrn_in_if.sink     i_in,
    nrn_out_if.source  o_out
);

    nrn_pkg::t_run  w_run;
    nrn_pkg::t_head w_head;
    logic           w_push;
    logic           w_q_ready;
    logic           w_pop;

    // Front: prefix tracking and rewrite rules, one run per accepted byte.
    nrn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_run     (w_run),
        .o_push    (w_push)
    );

    // Empty runs are never pushed, so the back end only sees real bytes.
    nrn_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_run),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Back: serializes the head run; run_last marks its final byte.
    nrn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* sv/nrn_checker.sv */
// nrn_checker: port-level assertions for the spelling normalizer, bound to the top.
// Depends on nasal_and_rww_spelling_normaliser_core.
`default_nettype none

module nrn_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_symbol,
    input wire logic       i_run_last
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Stalled output holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_symbol) && $stable(i_run_last))
        else $error("stalled output changed");

    // Terminators are dropped, never forwarded.
    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_symbol != 8'h00)
        else $error("NUL on output");

    // Whitespace is always the last byte of its request's run.
    a_ws_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_symbol == 8'h20 || i_out_symbol == 8'h0A ||
                        i_out_symbol == 8'h09) |-> i_run_last)
        else $error("whitespace not last of run");

endmodule

bind nasal_and_rww_spelling_normaliser_core nrn_checker u_nrn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.out_symbol),
    .i_run_last   (o_out.run_last)
);

`default_nettype wire

/* tb/sv/tb_nasal_and_rww_spelling_normaliser_core.sv */
// Testbench for nasal_and_rww_spelling_normaliser_core: directed table, then random words.
// Depends on nrn_if (channel interfaces) and the core; has its own byte-level predictor.
`timescale 1ns / 1ps

module tb_nasal_and_rww_spelling_normaliser_core;

    // Pending prefix of the predictor, same meaning as in the block.
    typedef enum logic [2:0] {
        PFX_IDLE,
        PFX_M,
        PFX_R,
        PFX_RW,
        PFX_RWW
    } prefix_t;

    // One expected output byte.
    typedef struct packed {
        logic [7:0] sym;
        logic       last;
    } out_byte_t;

    // One row of the directed table. Typed rows carry at most one byte.
    typedef struct packed {
        logic [7:0] sym;
        logic       text_end;
        logic       typed;
        logic       want_n;
        logic [7:0] want;
    } dir_row_t;

    localparam logic BY_MODEL = 1'b0;
    localparam logic BY_TABLE = 1'b1;
    localparam int   N_DIRECTED = 27;
    localparam int   N_RANDOM   = 220;

    logic i_clk;
    logic i_rst_n;

    nrn_in_if  in_if ();
    nrn_out_if out_if ();

    nasal_and_rww_spelling_normaliser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state and the bytes still owed by the block.
    prefix_t    prefix_state;
    logic [7:0] run_bytes [$];
    out_byte_t  expected_bytes [$];
    logic [7:0] word_queue [$];
    dir_row_t   directed_rows [N_DIRECTED];
    int         error_count;
    logic       calm;       // no idling on either side while set

    string VOWELS     = "aAiIuUqLeEoO";
    string CLASS_CONS = "kKgGfcCjJFtTdDNwWxXnpPbBm";

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void emit(input logic [7:0] b);
        if (run_bytes.size() < 4)
            run_bytes.push_back(b);
    endfunction

    // Write out whatever prefix is held and go back to idle.
    function automatic void flush_prefix();
        case (prefix_state)
            PFX_M:   emit("m");
            PFX_R:   emit("r");
            PFX_RW:  begin
                emit("r");
                emit("w");
            end
            PFX_RWW: begin
                emit("r");
                emit("w");
                emit("w");
            end
            default: ;
        endcase
        prefix_state = PFX_IDLE;
    endfunction

    // Bytes produced by one request, left in run_bytes.
    function automatic void normalise(input logic [7:0] c, input logic te);
        logic [7:0] nasal;
        logic       vowel;
        run_bytes.delete();
        if (c == " " || c == "\n" || c == "\t") begin
            flush_prefix();
            emit(c);
        end else if (c == 8'h00) begin
            // terminator: flush, byte itself dropped
            flush_prefix();
        end else begin
            case (prefix_state)
                PFX_M: begin
                    case (c)
                        "k", "K", "g", "G", "f": nasal = "f";
                        "c", "C", "j", "J", "F": nasal = "F";
                        "t", "T", "d", "D", "N": nasal = "N";
                        "w", "W", "x", "X", "n": nasal = "n";
                        "p", "P", "b", "B", "m": nasal = "m";
                        default:                 nasal = "M";
                    endcase
                    emit(nasal);
                    emit(c);
                    prefix_state = PFX_IDLE;
                end
                PFX_R: begin
                    if (c == "w") begin
                        prefix_state = PFX_RW;
                    end else begin
                        emit("r");
                        emit(c);
                        prefix_state = PFX_IDLE;
                    end
                end
                PFX_RW: begin
                    if (c == "w") begin
                        prefix_state = PFX_RWW;
                    end else begin
                        emit("r");
                        emit("w");
                        emit(c);
                        prefix_state = PFX_IDLE;
                    end
                end
                PFX_RWW: begin
                    case (c)
                        "a", "A", "i", "I", "u", "U",
                        "q", "L", "e", "E", "o", "O": vowel = 1'b1;
                        default:                      vowel = 1'b0;
                    endcase
                    // rww + vowel drops one w
                    emit("r");
                    emit("w");
                    if (!vowel)
                        emit("w");
                    emit(c);
                    prefix_state = PFX_IDLE;
                end
                default: begin
                    if (c == "M")
                        prefix_state = PFX_M;
                    else if (c == "r")
                        prefix_state = PFX_R;
                    else
                        emit(c);
                end
            endcase
        end
        if (te)
            flush_prefix();
    endfunction

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(6, 20);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 2))
            0:       return " ";
            1:       return "\t";
            default: return "\n";
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)      return "M";
        else if (r < 24) return "r";
        else if (r < 36) return "w";
        else if (r < 54) return VOWELS[$urandom_range(0, 11)];
        else if (r < 72) return CLASS_CONS[$urandom_range(0, 24)];
        else if (r < 84) return pick_space();
        else if (r < 88) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Two in ten draws start an rww sequence, two in ten an anusvara pair, the rest are single bytes and noise.
    function automatic logic [7:0] next_symbol();
        int r;
        if (word_queue.size() == 0) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                word_queue.push_back("r");
                word_queue.push_back("w");
                word_queue.push_back("w");
                if ($urandom_range(0, 2) != 0)
                    word_queue.push_back(VOWELS[$urandom_range(0, 11)]);
                else
                    word_queue.push_back(pick_byte());
            end else if (r < 4) begin
                word_queue.push_back("M");
                if ($urandom_range(0, 2) != 0)
                    word_queue.push_back(CLASS_CONS[$urandom_range(0, 24)]);
                else
                    word_queue.push_back(pick_byte());
            end else begin
                word_queue.push_back(pick_byte());
            end
        end
        return word_queue.pop_front();
    endfunction

    function automatic dir_row_t row(input logic [7:0] s, input logic te, input logic typed,
                                     input logic n, input logic [7:0] w);
        dir_row_t d;
        d.sym      = s;
        d.text_end = te;
        d.typed    = typed;
        d.want_n   = n;
        d.want     = w;
        return d;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("tb: mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one request; prediction is queued at the edge that accepts it.
    task automatic send_request(input logic [7:0] sym, input logic te, input logic typed,
                                input logic want_n, input logic [7:0] want);
        int        gap;
        out_byte_t ob;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.symbol   <= sym;
        in_if.text_end <= te;
        do @(posedge i_clk); while (!in_if.ready);
        normalise(sym, te);
        if (typed) begin
            // hand-typed expectation; predictor still ran to keep its state
            if (want_n) begin
                ob.sym  = want;
                ob.last = 1'b1;
                expected_bytes.push_back(ob);
            end
        end else begin
            foreach (run_bytes[i]) begin
                ob.sym  = run_bytes[i];
                ob.last = (i == run_bytes.size() - 1);
                expected_bytes.push_back(ob);
            end
        end
    endtask

    // Output monitor: compare every accepted byte with the oldest expectation.
    initial begin
        out_byte_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", out_if.out_symbol, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_if.out_symbol !== want.sym)
                        report_mismatch("out_symbol", out_if.out_symbol, want.sym);
                    if (out_if.run_last !== want.last)
                        report_mismatch("run_last", {7'b0, out_if.run_last}, {7'b0, want.last});
                end
            end
        end
    end

    // Output back-pressure: random stalls, short mostly, a few long.
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = pick_gap() - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        logic [7:0] sym;
        logic       te;
        error_count  = 0;
        calm         = 1'b0;
        prefix_state = PFX_IDLE;

        // Directed table: plain bytes, every nasal class, consumed bytes,
        // rww before a vowel, word end, text end and the terminator.
        directed_rows[0]  = row("a",   1'b0, BY_TABLE, 1'b1, "a");
        directed_rows[1]  = row(8'hFF, 1'b0, BY_TABLE, 1'b1, 8'hFF);
        directed_rows[2]  = row(8'h00, 1'b0, BY_TABLE, 1'b0, 8'h00);
        directed_rows[3]  = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[4]  = row("k",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[5]  = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[6]  = row("j",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[7]  = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[8]  = row("d",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[9]  = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[10] = row("x",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[11] = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[12] = row("B",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[13] = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[14] = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[15] = row("M",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[16] = row("\n",  1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[17] = row("r",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[18] = row("w",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[19] = row("w",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[20] = row("a",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[21] = row("r",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[22] = row("w",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[23] = row("w",   1'b1, BY_MODEL, 1'b0, 8'h00);
        directed_rows[24] = row("r",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[25] = row("r",   1'b0, BY_MODEL, 1'b0, 8'h00);
        directed_rows[26] = row("M",   1'b1, BY_TABLE, 1'b1, "m");

        in_if.valid    <= 1'b0;
        in_if.symbol   <= 8'h00;
        in_if.text_end <= 1'b0;
        i_rst_n        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++)
            send_request(directed_rows[k].sym, directed_rows[k].text_end,
                         directed_rows[k].typed, directed_rows[k].want_n,
                         directed_rows[k].want);

        for (int k = 0; k < N_RANDOM; k++) begin
            // halfway: hold off until the block has drained completely
            if (k == N_RANDOM / 2) begin
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (expected_bytes.size() != 0);
            end
            calm = (k >= 150 && k < 190);
            sym  = next_symbol();
            te   = ($urandom_range(0, 24) == 0);
            send_request(sym, te, BY_MODEL, 1'b0, 8'h00);
        end
        calm = 1'b0;

        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
sv/nrn_pkg.sv
sv/nrn_if.sv
sv/nrn_front.sv
sv/nrn_queue.sv
sv/nrn_back.sv
sv/nasal_and_rww_spelling_normaliser_core.sv
sv/nrn_checker.sv
tb/sv/tb_nasal_and_rww_spelling_normaliser_core.sv
